### sv/pgtr_pkg.sv
// shared types, codes and constants of the proportional glyph tile renderer
package pgtr_pkg;

	localparam int WA_W = 16;  // internal tile word address width
	localparam int GA_W = 13;  // internal glyph byte address width

	typedef enum logic [1:0] {
		REQ_RENDER = 2'd0,
		REQ_LOAD   = 2'd1,
		REQ_READ   = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_t;

	localparam logic CFG_TILE_BASE  = 1'b0;
	localparam logic CFG_TILE_COUNT = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DISPATCH,
		ST_TREAD,
		ST_RENDER,
		ST_SCAN,
		ST_EDGE,
		ST_DRAW_RD,
		ST_DRAW_WR,
		ST_KERN,
		ST_FINISH,
		ST_RESULT
	} state_t;

	localparam logic [6:0] CH_SPACE = 7'h20;
	localparam logic [6:0] CH_UNDER = 7'h5f;
	localparam logic [6:0] CH_FIRST = 7'd32;

	localparam logic [6:0] KERN_A [8] = '{7'h69, 7'h72, 7'h74, 7'h68, 7'h74, 7'h2f, 7'h54, 7'h46};
	localparam logic [6:0] KERN_B [8] = '{7'h74, 7'h65, 7'h74, 7'h74, 7'h70, 7'h2f, 7'h65, 7'h6f};

	function automatic logic kern_hit(input logic [6:0] c, input logic [6:0] n);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (c == KERN_A[i] && n == KERN_B[i]) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

endpackage

### sv/proportional_glyph_tile_renderer_unit.sv
// top level of the proportional glyph tile renderer
//
// one request is taken per transfer (start high while busy low); the block then stays busy
// until its single result appears for one cycle with done high, which the receiver must
// take at once since it cannot stall. a clear sweeps every word of the region to zero, and a
// render of a drawn glyph scans its columns through the glyph ram port, then draws each
// pixel column from the leftmost to the rightmost non-empty one (8 rows, each a read and a
// write of the tile ram). after reset the tile store is swept to zero, one word a cycle,
// and busy stays high meanwhile; configuration writes are taken at any time.
module proportional_glyph_tile_renderer_unit #(
	parameter int TILE_CAPACITY = 256,
	parameter int GLYPH_COUNT   = 96
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [6:0]  char_code,
	input  logic [6:0]  next_char,
	input  logic        first_of_string,
	input  logic        last_of_string,
	input  logic [7:0]  blank_offset,
	input  logic [11:0] mem_addr,
	input  logic [7:0]  glyph_byte,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_data,
	output logic        done,
	output logic [11:0] pen_x,
	output logic        stopped,
	output logic        string_done,
	output logic [7:0]  string_start_tile,
	output logic [8:0]  string_tiles,
	output logic [31:0] tile_word
);

	import pgtr_pkg::*;

	localparam int TAW = $clog2(TILE_CAPACITY * 8);
	localparam int GAW = $clog2(GLYPH_COUNT * 32);
	localparam logic [WA_W-1:0] WORDS_TOTAL = WA_W'(TILE_CAPACITY * 8);
	localparam logic [GA_W-1:0] GLYPH_BYTES = GA_W'(GLYPH_COUNT * 32);
	localparam logic [10:0]     CAP_TILES   = 11'(TILE_CAPACITY);

	state_t state_q, state_d;

	// configuration
	logic [7:0] tile_base_q;
	logic [8:0] tile_count_q;

	// latched request
	req_t       req_q;
	logic [6:0] char_q, next_q;
	logic       first_q, last_q;
	logic [7:0] blank_q;
	logic [11:0] addr_q;
	logic [7:0] gbyte_q;

	// renderer state
	logic [8:0]  next_tile_q, string_tile_q;
	logic [11:0] pen_q, budget_q;
	logic        halted_q;

	// sweep, scan and draw sequencing
	logic [WA_W-1:0] sw_q, sw_end_q;
	logic            sw_reply_q;
	logic [5:0]      sc_q;
	logic [3:0][7:0] colv_q;
	logic [2:0]      x_q, y_q, right_q;
	logic            done_q, sdone_q;
	logic [8:0]      stiles_q;
	logic [31:0]     word_q;

	// ram ports
	logic            t_we;
	logic [TAW-1:0]  t_waddr, t_raddr;
	logic [31:0]     t_wdata, t_rdata;
	logic            g_we;
	logic [GAW-1:0]  g_raddr;
	logic [7:0]      g_rdata;

	pgtr_ram #(.WIDTH(32), .DEPTH(TILE_CAPACITY * 8)) u_tile_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	pgtr_ram #(.WIDTH(8), .DEPTH(GLYPH_COUNT * 32)) u_glyph_ram (
		.clk   (clk),
		.we    (g_we),
		.waddr (addr_q[GAW-1:0]),
		.wdata (gbyte_q),
		.raddr (g_raddr),
		.rdata (g_rdata)
	);

	// glyph decode
	logic [6:0]      gidx;
	logic            glyph_ok;
	logic [GA_W-1:0] scan_ga, draw_ga;
	assign gidx     = char_q - CH_FIRST;
	assign glyph_ok = (char_q >= CH_FIRST) && ({25'd0, gidx} < GLYPH_COUNT);
	assign scan_ga  = {1'b0, gidx, sc_q[4:0]};
	assign draw_ga  = {1'b0, gidx, y_q, x_q[2:1]};

	// plot address of the current row at the pen
	logic [WA_W-1:0] tsum, draw_wa;
	logic            draw_in;
	assign tsum    = WA_W'(string_tile_q) + WA_W'(pen_q[11:3]);
	assign draw_wa = {tsum[WA_W-4:0], y_q};
	assign draw_in = draw_wa < WORDS_TOTAL;

	logic [3:0]  pix;
	assign pix = x_q[0] ? g_rdata[7:4] : g_rdata[3:0];

	// non-empty pixel columns, leftmost and rightmost
	logic [7:0] nz;
	logic [2:0] left_c, right_c;
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			nz[2*i]   = |colv_q[i][3:0];
			nz[2*i+1] = |colv_q[i][7:4];
		end
		left_c  = 3'd0;
		right_c = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (nz[i]) left_c = 3'(i);
		end
		for (int i = 0; i < 8; i++) begin
			if (nz[i]) right_c = 3'(i);
		end
	end

	// string start: room left in the region
	logic signed [10:0] room;
	logic [8:0]         room_sat;
	assign room     = $signed({3'd0, tile_base_q}) + $signed({2'd0, tile_count_q})
	                  - $signed({2'd0, next_tile_q});
	assign room_sat = (room > 11'sd256) ? 9'd256 : room[8:0];

	// clear region end, clipped to the store
	logic [10:0] clr_end_t;
	assign clr_end_t = (11'(tile_base_q) + 11'(tile_count_q) > CAP_TILES) ? CAP_TILES
	                   : 11'(tile_base_q) + 11'(tile_count_q);

	// pen advance through one adder
	logic [11:0] adv_n, pen_adv;
	assign pen_adv = pen_q + adv_n;

	logic [11:0] padded;
	assign padded = (pen_q + 12'd7) & ~12'd7;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and ram control
	always_comb begin
		state_d = state_q;
		t_we    = 1'b0;
		t_waddr = draw_wa[TAW-1:0];
		t_wdata = t_rdata | (32'(pix) << {pen_q[2:0], 2'b00});
		t_raddr = draw_wa[TAW-1:0];
		g_we    = 1'b0;
		g_raddr = draw_ga[GAW-1:0];
		adv_n   = 12'd1;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_DISPATCH;
			end
			ST_SWEEP: begin
				t_waddr = sw_q[TAW-1:0];
				t_wdata = '0;
				if (sw_q < sw_end_q) begin
					t_we = 1'b1;
				end else begin
					state_d = sw_reply_q ? ST_RESULT : ST_IDLE;
				end
			end
			ST_DISPATCH: begin
				t_raddr = addr_q[TAW-1:0];
				case (req_q)
					REQ_RENDER: state_d = ST_RENDER;
					REQ_LOAD: begin
						g_we    = {1'b0, addr_q} < GLYPH_BYTES;
						state_d = ST_RESULT;
					end
					REQ_READ:  state_d = ST_TREAD;
					REQ_CLEAR: state_d = ST_SWEEP;
					default:   state_d = ST_RESULT;
				endcase
			end
			ST_TREAD: state_d = ST_RESULT;
			ST_RENDER: begin
				adv_n = 12'd4;
				if (halted_q) begin
					state_d = ST_FINISH;
				end else if (char_q == CH_SPACE || char_q == CH_UNDER) begin
					state_d = ST_FINISH;
				end else if (glyph_ok) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_KERN;
				end
			end
			ST_SCAN: begin
				g_raddr = scan_ga[GAW-1:0];
				if (sc_q == 6'd32) state_d = ST_EDGE;
			end
			ST_EDGE: state_d = (nz == 8'd0) ? ST_KERN : ST_DRAW_RD;
			ST_DRAW_RD: state_d = ST_DRAW_WR;
			ST_DRAW_WR: begin
				t_we = draw_in;
				if (y_q == 3'd7) begin
					if (pen_adv > budget_q) begin
						state_d = ST_FINISH;
					end else if (x_q == right_q) begin
						state_d = ST_KERN;
					end else begin
						state_d = ST_DRAW_RD;
					end
				end else begin
					state_d = ST_DRAW_RD;
				end
			end
			ST_KERN:   state_d = ST_FINISH;
			ST_FINISH: state_d = ST_RESULT;
			ST_RESULT: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_base_q   <= 8'd0;
			tile_count_q  <= 9'd256;
			next_tile_q   <= 9'd0;
			string_tile_q <= 9'd0;
			pen_q         <= 12'd0;
			budget_q      <= 12'd0;
			halted_q      <= 1'b0;
			sw_q          <= '0;
			sw_end_q      <= WORDS_TOTAL;
			sw_reply_q    <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_TILE_BASE) tile_base_q <= cfg_data[7:0];
				if (cfg_index == CFG_TILE_COUNT) tile_count_q <= cfg_data;
			end
			done_q <= (state_q == ST_RESULT);
			case (state_q)
				ST_SWEEP: begin
					if (sw_q < sw_end_q) sw_q <= sw_q + 1'b1;
				end
				ST_DISPATCH: begin
					if (req_q == REQ_CLEAR) begin
						sw_q        <= WA_W'({tile_base_q, 3'b000});
						sw_end_q    <= WA_W'({clr_end_t, 3'b000});
						sw_reply_q  <= 1'b1;
						next_tile_q <= {1'b0, tile_base_q};
					end
					if (req_q == REQ_RENDER && first_q) begin
						string_tile_q <= next_tile_q;
						if (room <= 11'sd0) begin
							halted_q <= 1'b1;
							pen_q    <= 12'd0;
							budget_q <= 12'd0;
						end else begin
							halted_q <= 1'b0;
							pen_q    <= {4'd0, blank_q};
							budget_q <= {room_sat, 3'b000};
						end
					end
				end
				ST_RENDER: begin
					if (!halted_q && (char_q == CH_SPACE || char_q == CH_UNDER)) begin
						pen_q <= pen_adv;
						if (pen_adv > budget_q) halted_q <= 1'b1;
					end
				end
				ST_DRAW_WR: begin
					if (y_q == 3'd7) begin
						pen_q <= pen_adv;
						if (pen_adv > budget_q) halted_q <= 1'b1;
					end
				end
				ST_KERN: begin
					if (!kern_hit(char_q, next_q)) begin
						pen_q <= pen_adv;
						if (pen_adv > budget_q) halted_q <= 1'b1;
					end
				end
				ST_FINISH: begin
					if (last_q) begin
						pen_q       <= padded;
						next_tile_q <= next_tile_q + padded[11:3];
					end
				end
				default: ;
			endcase
		end
	end

	// request latch and datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				req_q   <= req_t'(req_type);
				char_q  <= char_code;
				next_q  <= next_char;
				first_q <= first_of_string;
				last_q  <= last_of_string;
				blank_q <= blank_offset;
				addr_q  <= mem_addr;
				gbyte_q <= glyph_byte;
			end
			ST_DISPATCH: begin
				sdone_q  <= 1'b0;
				stiles_q <= 9'd0;
				word_q   <= 32'd0;
			end
			ST_TREAD: begin
				if ({4'd0, addr_q} < WORDS_TOTAL) word_q <= t_rdata;
			end
			ST_RENDER: begin
				sc_q   <= 6'd0;
				colv_q <= '0;
			end
			ST_SCAN: begin
				sc_q <= sc_q + 1'b1;
				if (sc_q != 6'd0) begin
					colv_q[sc_q[1:0] - 2'd1] <= colv_q[sc_q[1:0] - 2'd1] | g_rdata;
				end
			end
			ST_EDGE: begin
				x_q     <= left_c;
				y_q     <= 3'd0;
				right_q <= right_c;
			end
			ST_DRAW_WR: begin
				y_q <= y_q + 1'b1;
				if (y_q == 3'd7) x_q <= x_q + 1'b1;
			end
			ST_FINISH: begin
				if (last_q) begin
					sdone_q  <= 1'b1;
					stiles_q <= padded[11:3];
				end
			end
			default: ;
		endcase
	end

	assign busy              = (state_q != ST_IDLE);
	assign done              = done_q;
	assign pen_x             = pen_q;
	assign stopped           = halted_q;
	assign string_done       = sdone_q;
	assign string_start_tile = string_tile_q[7:0];
	assign string_tiles      = stiles_q;
	assign tile_word         = word_q;

	// an accepted request always leaves the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accept did not raise busy");

	// a result strobe follows the result state
	a_done_after: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without work");

	// a finished string covers exactly its padded width
	a_tiles_pen: assert property (@(posedge clk) disable iff (!arst_n)
		(done && string_done) |-> (string_tiles == pen_x[11:3] && pen_x[2:0] == 3'd0))
		else $error("string tile count mismatch");

endmodule

### sv/pgtr_ram.sv
// generic single write port ram with registered read
module pgtr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### verif/pgtr_checker.sv
// checker for the glyph tile renderer: watches transfers, predicts results and compares them
`timescale 1ns / 100ps

module pgtr_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  req_type,
	input  logic [6:0]  char_code,
	input  logic [6:0]  next_char,
	input  logic        first_of_string,
	input  logic        last_of_string,
	input  logic [7:0]  blank_offset,
	input  logic [11:0] mem_addr,
	input  logic [7:0]  glyph_byte,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        done,
	input  logic [11:0] pen_x,
	input  logic        stopped,
	input  logic        string_done,
	input  logic [7:0]  string_start_tile,
	input  logic [8:0]  string_tiles,
	input  logic [31:0] tile_word,
	output int          errors,
	output int          pending
);

	import pgtr_pkg::*;

	localparam int TILES  = 256;
	localparam int GLYPHS = 96;
	localparam int WORDS  = TILES * 8;
	localparam int GBYTES = GLYPHS * 32;

	typedef struct packed {
		logic [11:0] pen;
		logic        halt;
		logic        sdone;
		logic [7:0]  stile;
		logic [8:0]  ntiles;
		logic [31:0] word;
	} text_result_t;

	// pairs that render with no gap between them
	localparam logic [6:0] PAIR_L [8] = '{7'("i"), 7'("r"), 7'("t"), 7'("h"), 7'("t"),
		7'("/"), 7'("T"), 7'("F")};
	localparam logic [6:0] PAIR_R [8] = '{7'("t"), 7'("e"), 7'("t"), 7'("t"), 7'("p"),
		7'("/"), 7'("e"), 7'("o")};

	logic [31:0] tiles_mdl [WORDS];
	logic [7:0]  glyphs_mdl [GBYTES];
	logic [7:0]  base_reg;
	logic [8:0]  count_reg;
	logic [8:0]  next_tile_m;
	logic [8:0]  str_tile_m;
	int          pen_m;
	logic        halt_m;
	int          budget_m;
	text_result_t text_results_q [$];

	function automatic void pen_step(int n);
		pen_m += n;
		if (pen_m > budget_m) begin
			halt_m = 1'b1;
		end
	endfunction

	function automatic void draw_char(logic [6:0] c, logic [6:0] nc);
		int gbase;
		int lcol;
		int rcol;
		logic [7:0] acc;
		logic [7:0] b;
		logic [3:0] pix;
		int w;
		logic pair;
		if (halt_m) begin
			return;
		end
		if (c == CH_SPACE || c == CH_UNDER) begin
			pen_step(4);
			return;
		end
		if (c >= CH_FIRST && int'(c) - 32 < GLYPHS) begin
			gbase = (int'(c) - 32) * 32;
			lcol = -1;
			rcol = -1;
			for (int k = 0; k < 4; k++) begin
				acc = '0;
				for (int y = 0; y < 8; y++) begin
					acc |= glyphs_mdl[gbase + y * 4 + k];
				end
				if (acc[3:0] != 0) begin
					if (lcol < 0) lcol = 2 * k;
					rcol = 2 * k;
				end
				if (acc[7:4] != 0) begin
					if (lcol < 0) lcol = 2 * k + 1;
					rcol = 2 * k + 1;
				end
			end
			if (lcol >= 0) begin
				for (int x = lcol; x <= rcol; x++) begin
					for (int y = 0; y < 8; y++) begin
						b = glyphs_mdl[gbase + y * 4 + x / 2];
						pix = x[0] ? b[7:4] : b[3:0];
						w = (int'(str_tile_m) + pen_m / 8) * 8 + y;
						if (w < WORDS) begin
							tiles_mdl[w] |= 32'(pix) << ((pen_m % 8) * 4);
						end
					end
					pen_step(1);
					if (halt_m) begin
						return;
					end
				end
			end
		end
		pair = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (c == PAIR_L[i] && nc == PAIR_R[i]) pair = 1'b1;
		end
		if (!pair) begin
			pen_step(1);
		end
	endfunction

	function automatic text_result_t predict_request();
		text_result_t r;
		int room;
		int padded;
		r = '0;
		case (req_t'(req_type))
			REQ_RENDER: begin
				if (first_of_string) begin
					room = int'(base_reg) + int'(count_reg) - int'(next_tile_m);
					str_tile_m = next_tile_m;
					if (room <= 0) begin
						halt_m = 1'b1;
						pen_m = 0;
						budget_m = 0;
					end else begin
						if (room > 256) room = 256;
						budget_m = room * 8;
						pen_m = blank_offset;
						halt_m = 1'b0;
					end
				end
				draw_char(char_code, next_char);
				if (last_of_string) begin
					padded = (pen_m + 7) & ~7;
					pen_m = padded;
					r.ntiles = 9'(padded >> 3);
					next_tile_m = 9'(int'(next_tile_m) + (padded >> 3));
					r.sdone = 1'b1;
				end
			end
			REQ_LOAD: begin
				if (mem_addr < GBYTES) glyphs_mdl[mem_addr] = glyph_byte;
			end
			REQ_READ: begin
				if (mem_addr < WORDS) r.word = tiles_mdl[mem_addr];
			end
			default: begin
				for (int t = base_reg; t < int'(base_reg) + int'(count_reg); t++) begin
					if (t >= TILES) break;
					for (int k = 0; k < 8; k++) tiles_mdl[t * 8 + k] = '0;
				end
				next_tile_m = 9'(base_reg);
			end
		endcase
		r.pen = 12'(pen_m);
		r.halt = halt_m;
		r.stile = str_tile_m[7:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		text_result_t want;
		if (!arst_n) begin
			foreach (tiles_mdl[i]) tiles_mdl[i] = '0;
			foreach (glyphs_mdl[i]) glyphs_mdl[i] = '0;
			base_reg = '0;
			count_reg = 9'd256;
			next_tile_m = '0;
			str_tile_m = '0;
			pen_m = 0;
			halt_m = 1'b0;
			budget_m = 0;
			text_results_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (done) begin
				if (text_results_q.size() == 0) begin
					report_mismatch("done with no request outstanding", 1, 0);
				end else begin
					want = text_results_q.pop_front();
					if (pen_x != want.pen) report_mismatch("pen_x", pen_x, want.pen);
					if (stopped != want.halt) report_mismatch("stopped", stopped, want.halt);
					if (string_done != want.sdone)
						report_mismatch("string_done", string_done, want.sdone);
					if (string_start_tile != want.stile)
						report_mismatch("string_start_tile", string_start_tile, want.stile);
					if (string_tiles != want.ntiles)
						report_mismatch("string_tiles", string_tiles, want.ntiles);
					if (tile_word != want.word) report_mismatch("tile_word", tile_word, want.word);
				end
			end
			if (cfg_we) begin
				if (cfg_index == CFG_TILE_BASE) base_reg = cfg_data[7:0];
				else count_reg = cfg_data;
			end
			if (start && !busy) begin
				text_results_q.push_back(predict_request());
			end
			pending = text_results_q.size();
		end
	end

endmodule

### verif/tb.sv
// testbench top: stimulus for the glyph tile renderer and the final verdict
`timescale 1ns / 100ps

module tb;
	import pgtr_pkg::*;

	localparam int LIMIT = 3000000;   // generous cycle limit

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  req_type;
	logic [6:0]  char_code;
	logic [6:0]  next_char;
	logic        first_of_string;
	logic        last_of_string;
	logic [7:0]  blank_offset;
	logic [11:0] mem_addr;
	logic [7:0]  glyph_byte;
	logic        cfg_we;
	logic        cfg_index;
	logic [8:0]  cfg_data;
	logic        done;
	logic [11:0] pen_x;
	logic        stopped;
	logic        string_done;
	logic [7:0]  string_start_tile;
	logic [8:0]  string_tiles;
	logic [31:0] tile_word;
	int          errors;
	int          pending;
	int          cycles = 0;
	bit          idle_en;

	// glyphs that get fully loaded; only these may be rendered
	logic [6:0] drawn_set [16] = '{7'("i"), 7'("t"), 7'("r"), 7'("e"), 7'("h"), 7'("p"),
		7'("/"), 7'("T"), 7'("F"), 7'("o"), 7'("A"), 7'("W"), 7'("."), 7'("|"), 7'("M"),
		7'h7f};
	// kerning pairs, left then right character
	logic [6:0] pair_l [8] = '{7'("i"), 7'("r"), 7'("t"), 7'("h"), 7'("t"), 7'("/"),
		7'("T"), 7'("F")};
	logic [6:0] pair_r [8] = '{7'("t"), 7'("e"), 7'("t"), 7'("t"), 7'("p"), 7'("/"),
		7'("e"), 7'("o")};
	// register settings of the random phases
	logic [7:0] phase_base [6] = '{8'd0, 8'd255, 8'd0, 8'd3, 8'd200, 8'd17};
	logic [8:0] phase_count [6] = '{9'd256, 9'd256, 9'd0, 9'd1, 9'd100, 9'd40};

	proportional_glyph_tile_renderer_unit dut (.*);

	pgtr_checker chk (.*);

	always #10 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// one request transfer; start stays high on return unless a random idle gap drops it
	task automatic send(logic [1:0] rq, logic [6:0] c, logic [6:0] nc, logic f, logic l,
			logic [7:0] blank, logic [11:0] addr, logic [7:0] gb);
		req_type        <= rq;
		char_code       <= c;
		next_char       <= nc;
		first_of_string <= f;
		last_of_string  <= l;
		blank_offset    <= blank;
		mem_addr        <= addr;
		glyph_byte      <= gb;
		start           <= 1'b1;
		do @(posedge clk); while (busy);
		// random gap after the transfer, about 31 in 100
		if (idle_en && $urandom_range(99) < 31) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic render(logic [6:0] c, logic [6:0] nc, logic f, logic l, logic [7:0] blank);
		send(REQ_RENDER, c, nc, f, l, blank, 12'($urandom), 8'($urandom));
	endtask

	// let every outstanding result land, then write both registers
	task automatic configure(logic [7:0] base, logic [8:0] count);
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_TILE_BASE;
		cfg_data  <= 9'(base);
		@(posedge clk);
		cfg_index <= CFG_TILE_COUNT;
		cfg_data  <= count;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [11:0] glyph_addr(logic [6:0] c);
		return 12'((int'(c) - 32) * 32 + $urandom_range(31));
	endfunction

	initial begin
		logic [7:0] colmask;
		logic [7:0] b;
		logic [6:0] c;
		logic [6:0] nc;
		logic       in_str;
		logic       f;
		logic       l;
		int         pick;
		int         k;

		clk = 1'b0;
		idle_en = 1'b1;
		arst_n <= 1'b0;
		start <= 1'b0;
		req_type <= REQ_RENDER;
		char_code <= '0;
		next_char <= '0;
		first_of_string <= 1'b0;
		last_of_string <= 1'b0;
		blank_offset <= '0;
		mem_addr <= '0;
		glyph_byte <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_TILE_BASE;
		cfg_data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// glyph setup: '.' stays empty, '|' full, others with random column shapes
		foreach (drawn_set[g]) begin
			colmask = (drawn_set[g] == ".") ? 8'h00 : (drawn_set[g] == "|") ? 8'hff :
				8'($urandom) | 8'(1 << $urandom_range(7));
			for (int a = 0; a < 32; a++) begin
				k = a % 4;
				b = (drawn_set[g] == "|") ? 8'hff : 8'($urandom);
				b &= {{4{colmask[2 * k + 1]}}, {4{colmask[2 * k]}}};
				send(REQ_LOAD, '0, '0, 0, 0, '0, 12'((int'(drawn_set[g]) - 32) * 32 + a), b);
			end
		end

		// directed part: kerning pairs, blanks, extremes, reads, a load and a clear
		render(7'("F"), 7'("o"), 1, 0, 8'd0);
		render(7'("o"), 7'("i"), 0, 0, 8'd0);
		for (int i = 0; i < 8; i++) render(pair_l[i], pair_r[i], 0, 0, 8'd0);
		render(7'd0, 7'h7f, 0, 0, 8'd0);
		render(7'(" "), 7'("_"), 0, 0, 8'd0);
		render(7'("_"), 7'd0, 0, 0, 8'd0);
		render(7'h7f, 7'd0, 0, 1, 8'd0);
		render(7'("|"), 7'("|"), 1, 1, 8'd255);
		send(REQ_READ, '0, '0, 0, 0, '0, 12'd0, '0);
		send(REQ_READ, '0, '0, 0, 0, '0, 12'd2047, '0);
		send(REQ_READ, '0, '0, 0, 0, '0, 12'd4095, '0);
		send(REQ_LOAD, '0, '0, 0, 0, '0, 12'd4095, 8'hff);
		send(REQ_CLEAR, '0, '0, 0, 0, '0, '0, '0);
		send(REQ_READ, '0, '0, 0, 0, '0, 12'd8, '0);

		// tight budget: the glyph is cut off, then the region has no room at all
		configure(8'd0, 9'd1);
		send(REQ_CLEAR, '0, '0, 0, 0, '0, '0, '0);
		render(7'("W"), 7'("M"), 1, 0, 8'd6);
		render(7'("M"), 7'd0, 0, 1, 8'd0);
		render(7'("A"), 7'd0, 1, 1, 8'd0);

		// random part in phases of register settings
		in_str = 1'b0;
		for (int n = 0; n < 1350; n++) begin
			if (n % 225 == 0) begin
				configure(phase_base[n / 225], phase_count[n / 225]);
				send(REQ_CLEAR, '0, '0, 0, 0, '0, '0, '0);
			end
			idle_en = !(n >= 400 && n < 700);
			pick = $urandom_range(99);
			if (pick < 72) begin
				k = $urandom_range(99);
				if (k < 20) begin
					pick = $urandom_range(7);
					c = pair_l[pick];
					nc = pair_r[pick];
				end else begin
					c = (k < 32) ? 7'($urandom_range(31)) :
						(k < 40) ? (k[0] ? 7'(" ") : 7'("_")) :
						drawn_set[$urandom_range(15)];
					nc = 7'($urandom);
				end
				// mostly well-formed strings, sometimes a missing start
				f = !in_str ? ($urandom_range(19) != 0) : ($urandom_range(29) == 0);
				l = ($urandom_range(5) == 0);
				in_str = !l;
				render(c, nc, f, l, ($urandom_range(9) == 0) ? 8'($urandom) :
					8'($urandom_range(7)));
			end else if (pick < 82) begin
				send(REQ_LOAD, '0, '0, 0, 0, '0,
					($urandom_range(3) == 0) ? 12'($urandom_range(3072, 4095)) :
					glyph_addr(drawn_set[$urandom_range(15)]), 8'($urandom));
			end else if (pick < 97) begin
				send(REQ_READ, 7'($urandom), '0, 0, 0, '0,
					($urandom_range(9) == 0) ? 12'($urandom_range(2048, 4095)) :
					12'($urandom_range(2047)), 8'($urandom));
			end else if (pick < 99) begin
				send(REQ_CLEAR, '0, '0, 0, 0, '0, '0, '0);
			end else begin
				// pause until the block has drained
				start <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
		end

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
